// ----- hdl/msld_pkg.sv -----
package msld_pkg;

  localparam int unsigned NBITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BUILD = 3'b010,
    ST_SHIFT = 3'b100
  } msld_state_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_FEEDBACK = 3'd1,
    OP_SET_MODE = 3'd2,
    OP_SET_SYS  = 3'd3,
    OP_REFRESH  = 3'd4,
    OP_SINGLE   = 3'd5
  } msld_op_t;

  localparam logic [2:0] MODE_CURRENT  = 3'd0;
  localparam logic [2:0] MODE_SPEED    = 3'd1;
  localparam logic [2:0] MODE_POSITION = 3'd2;
  localparam logic [2:0] MODE_DISABLED = 3'd3;

  localparam logic [1:0] SYS_EMERGENCY = 2'd0;
  localparam logic [1:0] SYS_DRIVE     = 2'd1;
  localparam logic [1:0] SYS_READY     = 2'd2;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  localparam logic [10:0] PH2000_LAST = 11'd1999;
  localparam logic [9:0]  PH1000_LAST = 10'd999;
  localparam logic [7:0]  PH200_LAST  = 8'd199;
  localparam logic [10:0] PULSE_LEN   = 11'd100;
  localparam logic [9:0]  HALF_1000   = 10'd500;
  localparam logic [7:0]  HALF_200    = 8'd100;

  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [7:0]  LED_MAX     = 8'd16;

endpackage

// ----- hdl/motor_status_led_shift_driver.sv -----
// motor status led shift driver
// in_*  : command beats (tick, feedback, mode, system state, refresh, single led).
//         in_tready is high only while the block is idle; ops other than
//         refresh and single led complete in the cycle they are accepted.
// out_* : one beat per shift register clock pulse. a run is 16 shift beats
//         carrying the pattern msb first, then one latch beat with tlast set.
// cfg_* : feedback timeout in ms, written whenever cfg_wr_en is high.
// flow: a refresh first scans the motors, one per cycle (min(NUM_MOTORS,16) motors,
//   one 32-bit age subtract and compare each), then shifts the pattern out
//   through a 16-bit shift register one bit per beat; a single led command
//   goes straight to the shift.
// the next command is taken once the latch beat sits in the output register.
// a stalled receiver holds the current beat and freezes the shift.
// reset (synchronous, rst_n low): time, stamps, modes and pattern clear,
//   system state goes to ready, timeout to 200 ms, green led off.
module motor_status_led_shift_driver
  import msld_pkg::*;
#(
  parameter int unsigned NUM_MOTORS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0] motor_index[6:3] motor_mode[9:7] system_state[11:10]
  // led_number[19:12] led_action[21:20], zero fill above
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // serial_bit[0] status_lamp[1], zero fill above
  output logic [7:0]  out_tdata,
  // beat_kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned NLIT  = (NUM_MOTORS < NBITS) ? NUM_MOTORS : NBITS;
  localparam int unsigned IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int unsigned LIT_W = (NLIT > 1) ? $clog2(NLIT) : 1;

  logic [2:0] in_op;
  logic [3:0] in_motor_index;
  logic [2:0] in_motor_mode;
  logic [1:0] in_system_state;
  logic [7:0] in_led_number;
  logic [1:0] in_led_action;

  assign in_op           = in_tdata[2:0];
  assign in_motor_index  = in_tdata[6:3];
  assign in_motor_mode   = in_tdata[9:7];
  assign in_system_state = in_tdata[11:10];
  assign in_led_number   = in_tdata[19:12];
  assign in_led_action   = in_tdata[21:20];

  msld_state_t state_r, state_nxt;

  logic [15:0] timeout_r;
  logic [31:0] time_r;
  logic [10:0] ph2000_r;
  logic [9:0]  ph1000_r;
  logic [7:0]  ph200_r;
  logic [31:0] stamp_r [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] stamp_vld_r;
  logic [2:0]  mode_r [NUM_MOTORS];
  logic [1:0]  sys_r;
  logic [15:0] shown_r;
  logic        green_r;
  logic        green_new_r;
  logic [15:0] sh_r;
  logic [LIT_W-1:0] scan_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;
  logic        out_bit_r;
  logic        out_green_r;
  logic        out_kind_r;
  logic        out_last_r;

  logic               in_fire;
  logic               idx_ok;
  logic [IDX_W+3:0]   idx_ext;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W+LIT_W-1:0] scan_ext;
  logic [IDX_W-1:0]   rd_idx;
  logic [3:0]         pat_pos;
  logic [31:0]        stamp_rd;
  logic [31:0]        age;
  logic               alive;
  logic               lit;
  logic               green_calc;
  logic [3:0]         led_pos;
  logic [15:0]        led_mask;
  logic [15:0]        single_pat;
  logic               led_ok;
  logic               slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_green_r, out_bit_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign slot_free  = ~out_valid_r | out_tready;

  assign idx_ok   = 32'(in_motor_index) < NUM_MOTORS;
  assign idx_ext  = {{IDX_W{1'b0}}, in_motor_index};
  assign wr_idx   = idx_ext[IDX_W-1:0];
  assign scan_ext = {{IDX_W{1'b0}}, scan_r};
  assign rd_idx   = scan_ext[IDX_W-1:0];
  assign pat_pos  = 4'(scan_r);

  assign stamp_rd = stamp_vld_r[rd_idx] ? stamp_r[rd_idx] : 32'd0;
  assign age      = time_r - stamp_rd;
  assign alive    = age <= {16'b0, timeout_r};

  always_comb begin
    case (mode_r[rd_idx])
      MODE_SPEED:    lit = 1'b1;
      MODE_POSITION: lit = ph1000_r < HALF_1000;
      MODE_CURRENT:  lit = ph200_r < HALF_200;
      MODE_DISABLED: lit = ph2000_r < PULSE_LEN;
      default:       lit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (sys_r)
      SYS_EMERGENCY: green_calc = 1'b0;
      SYS_DRIVE:     green_calc = 1'b1;
      default:       green_calc = ph2000_r < PULSE_LEN;
    endcase
  end

  assign led_ok   = (in_led_number != 8'd0) && (in_led_number <= LED_MAX);
  assign led_pos  = 4'(in_led_number - 8'd1);
  assign led_mask = 16'd1 << led_pos;

  always_comb begin
    case (in_led_action)
      ACT_CLEAR:  single_pat = shown_r & ~led_mask;
      ACT_SET:    single_pat = shown_r | led_mask;
      ACT_TOGGLE: single_pat = shown_r ^ led_mask;
      default:    single_pat = shown_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_REFRESH) begin
          state_nxt = ST_BUILD;
        end else if (in_fire && in_op == OP_SINGLE && led_ok) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_BUILD: begin
        if (32'(scan_r) == NLIT - 1) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (slot_free && cnt_r == 5'(NBITS)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timeout_r   <= TIMEOUT_RST;
      time_r      <= 32'd0;
      ph2000_r    <= 11'd0;
      ph1000_r    <= 10'd0;
      ph200_r     <= 8'd0;
      stamp_vld_r <= '0;
      sys_r       <= SYS_READY;
      shown_r     <= 16'd0;
      green_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        mode_r[i] <= MODE_CURRENT;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (state_r == ST_SHIFT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_op)
              OP_TICK: begin
                time_r <= time_r + 32'd1;
                if (time_r == '1) begin
                  ph2000_r <= 11'd0;
                  ph1000_r <= 10'd0;
                  ph200_r  <= 8'd0;
                end else begin
                  ph2000_r <= (ph2000_r == PH2000_LAST) ? 11'd0 : ph2000_r + 11'd1;
                  ph1000_r <= (ph1000_r == PH1000_LAST) ? 10'd0 : ph1000_r + 10'd1;
                  ph200_r  <= (ph200_r == PH200_LAST) ? 8'd0 : ph200_r + 8'd1;
                end
              end
              OP_FEEDBACK: begin
                if (idx_ok) begin
                  stamp_vld_r[wr_idx] <= 1'b1;
                end
              end
              OP_SET_MODE: begin
                if (idx_ok) begin
                  mode_r[wr_idx] <= in_motor_mode;
                end
              end
              OP_SET_SYS: sys_r <= in_system_state;
              OP_SINGLE: begin
                if (led_ok) begin
                  shown_r <= single_pat;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BUILD: begin
          if (32'(scan_r) == NLIT - 1) begin
            shown_r <= sh_r | ({15'b0, alive & lit} << pat_pos);
          end
        end
        ST_SHIFT: begin
          if (slot_free) begin
            if (cnt_r == 5'(NBITS)) begin
              green_r <= green_new_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_FEEDBACK && idx_ok) begin
      stamp_r[wr_idx] <= time_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        scan_r <= '0;
        cnt_r  <= 5'd0;
        if (in_fire && in_op == OP_REFRESH) begin
          sh_r        <= 16'd0;
          green_new_r <= green_calc;
        end else if (in_fire && in_op == OP_SINGLE) begin
          sh_r        <= single_pat;
          green_new_r <= green_r;
        end
      end
      ST_BUILD: begin
        sh_r   <= sh_r | ({15'b0, alive & lit} << pat_pos);
        scan_r <= scan_r + LIT_W'(1);
      end
      ST_SHIFT: begin
        if (slot_free) begin
          if (cnt_r == 5'(NBITS)) begin
            out_bit_r   <= 1'b0;
            out_green_r <= green_new_r;
            out_kind_r  <= 1'b1;
            out_last_r  <= 1'b1;
          end else begin
            out_bit_r   <= sh_r[15];
            out_green_r <= green_r;
            out_kind_r  <= 1'b0;
            out_last_r  <= 1'b0;
            sh_r        <= {sh_r[14:0], 1'b0};
            cnt_r       <= cnt_r + 5'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/msld_beat_checker.sv -----
`timescale 1ns / 1ps

module msld_beat_checker
  import msld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,
  input  logic              out_tuser,
  input  logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  output int unsigned       fail_count,
  output int unsigned       beats_due
);

  typedef struct packed {
    logic serial_bit;
    logic beat_kind;
    logic last_beat;
    logic status_lamp;
  } led_beat_t;

  led_beat_t   led_beats_q[$];
  int unsigned errs = 0;
  int unsigned due_count = 0;

  logic [31:0] now_ms;
  logic [31:0] fb_stamp [16];
  logic [2:0]  motor_mode [16];
  logic [1:0]  sys_state;
  logic [15:0] latched_pattern;
  logic        green_now;
  logic [15:0] timeout_ms;

  assign fail_count = errs;
  assign beats_due  = due_count;

  function automatic logic motor_lit(int i);
    logic [31:0] age;
    age = now_ms - fb_stamp[i];
    if (age > {16'd0, timeout_ms}) return 1'b0;
    case (motor_mode[i])
      MODE_SPEED:    return 1'b1;
      MODE_POSITION: return (now_ms % 32'd1000) < 32'd500;
      MODE_CURRENT:  return (now_ms % 32'd200) < 32'd100;
      MODE_DISABLED: return (now_ms % 32'd2000) < 32'd100;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic queue_run(input logic [15:0] pattern, input logic green_after);
    led_beat_t b;
    for (int k = 0; k < 16; k++) begin
      b.serial_bit  = pattern[15 - k];
      b.beat_kind   = 1'b0;
      b.last_beat   = 1'b0;
      b.status_lamp = green_now;
      led_beats_q.push_back(b);
    end
    latched_pattern = pattern;
    green_now       = green_after;
    b.serial_bit  = 1'b0;
    b.beat_kind   = 1'b1;
    b.last_beat   = 1'b1;
    b.status_lamp = green_now;
    led_beats_q.push_back(b);
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      errs++;
    end
  endtask

  task automatic predict_command(input logic [23:0] word);
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [7:0]  num;
    logic [1:0]  act;
    logic [15:0] pat;
    logic [15:0] mask;
    logic        g;
    op  = word[2:0];
    idx = word[6:3];
    num = word[19:12];
    act = word[21:20];
    case (op)
      OP_TICK:     now_ms = now_ms + 32'd1;
      OP_FEEDBACK: fb_stamp[idx] = now_ms;
      OP_SET_MODE: motor_mode[idx] = word[9:7];
      OP_SET_SYS:  sys_state = word[11:10];
      OP_REFRESH: begin
        for (int i = 0; i < 16; i++) pat[i] = motor_lit(i);
        case (sys_state)
          SYS_EMERGENCY: g = 1'b0;
          SYS_DRIVE:     g = 1'b1;
          default:       g = (now_ms % 32'd2000) < 32'd100;
        endcase
        queue_run(pat, g);
      end
      OP_SINGLE: begin
        if (num != 8'd0 && num <= LED_MAX) begin
          mask = 16'h1 << (num - 8'd1);
          pat  = latched_pattern;
          case (act)
            ACT_CLEAR:  pat = pat & ~mask;
            ACT_SET:    pat = pat | mask;
            ACT_TOGGLE: pat = pat ^ mask;
            default:    pat = pat;
          endcase
          queue_run(pat, green_now);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    led_beat_t want;
    if (!rst_n) begin
      now_ms          = '0;
      sys_state       = SYS_READY;
      latched_pattern = '0;
      green_now       = 1'b0;
      timeout_ms      = TIMEOUT_RST;
      for (int i = 0; i < 16; i++) begin
        fb_stamp[i]   = '0;
        motor_mode[i] = '0;
      end
      led_beats_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (led_beats_q.size() == 0) begin
          $error("output beat with nothing due: tdata %h tuser %b tlast %b",
                 out_tdata, out_tuser, out_tlast);
          errs++;
        end else begin
          want = led_beats_q.pop_front();
          check_bit("serial_bit", want.serial_bit, out_tdata[0]);
          check_bit("beat_kind", want.beat_kind, out_tuser);
          check_bit("last_beat", want.last_beat, out_tlast);
          check_bit("status_lamp", want.status_lamp, out_tdata[1]);
        end
      end
      if (cfg_wr_en) timeout_ms = cfg_wr_data;
      if (in_tvalid && in_tready) predict_command(in_tdata);
    end
    due_count = led_beats_q.size();
  end

endmodule

// ----- tb/tb_motor_status_led_shift_driver.sv -----
`timescale 1ns / 1ps

module tb_motor_status_led_shift_driver;
  import msld_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int unsigned fail_count;
  int unsigned beats_due;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  motor_status_led_shift_driver u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  msld_beat_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .beats_due   (beats_due)
  );

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < 12)
      stall_left = $urandom_range(1, 11);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_motor_status_led_shift_driver: done, errors");
      $finish;
    end
  end

  function automatic logic [23:0] pack_cmd(input logic [2:0] op, input logic [3:0] idx,
                                           input logic [2:0] mode, input logic [1:0] sys,
                                           input logic [7:0] num, input logic [1:0] act);
    return {2'b00, act, num, sys, mode, idx, op};
  endfunction

  function automatic logic [23:0] rand_cmd(input logic [2:0] op);
    return pack_cmd(op, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                    2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)));
  endfunction

  task automatic send_cmd(input logic [23:0] word);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_cmd(rand_cmd(OP_TICK));
  endtask

  // drain all beats, let the block go idle, then load a new timeout
  task automatic settle_and_load(input logic [15:0] timeout);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= timeout;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int          pick;
    logic [23:0] word;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        tick_run($urandom_range(1, 7));
      end else if (pick < 45) begin
        send_cmd(rand_cmd(OP_FEEDBACK));
      end else if (pick < 57) begin
        word = rand_cmd(OP_SET_MODE);
        if ($urandom_range(0, 9) < 7) word[9:7] = 3'($urandom_range(0, 3));
        send_cmd(word);
      end else if (pick < 63) begin
        send_cmd(rand_cmd(OP_SET_SYS));
      end else if (pick < 83) begin
        send_cmd(rand_cmd(OP_REFRESH));
      end else if (pick < 97) begin
        word = rand_cmd(OP_SINGLE);
        if ($urandom_range(0, 99) < 85) word[19:12] = 8'($urandom_range(1, 16));
        send_cmd(word);
      end else begin
        send_cmd(rand_cmd($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset state, all motors alive in current mode
    send_cmd(pack_cmd(OP_REFRESH, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));
    // out of range led numbers, then in range ones with clear, set, toggle and the spare action
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd0, ACT_SET));
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd17, ACT_SET));
    send_cmd(pack_cmd(OP_SINGLE, 4'd15, 3'd7, 2'd3, 8'd255, 2'd3));
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd1, ACT_CLEAR));
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd16, ACT_SET));
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd8, ACT_TOGGLE));
    send_cmd(pack_cmd(OP_SINGLE, 4'd0, 3'd0, 2'd0, 8'd3, 2'd3));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd0, MODE_SPEED, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd1, MODE_POSITION, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd2, MODE_DISABLED, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd3, 3'd4, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd15, 3'd7, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_MODE, 4'd14, 3'd5, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_SYS, 4'd0, 3'd0, SYS_EMERGENCY, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_REFRESH, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_SYS, 4'd0, 3'd0, SYS_DRIVE, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SPARE_6, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SPARE_7, 4'd15, 3'd7, 2'd3, 8'd255, 2'd3));
    tick_run(6);
    send_cmd(pack_cmd(OP_FEEDBACK, 4'd15, 3'd0, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_FEEDBACK, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_REFRESH, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));
    send_cmd(pack_cmd(OP_SET_SYS, 4'd0, 3'd0, 2'd3, 8'd0, 2'd0));
    tick_run(9);
    send_cmd(pack_cmd(OP_REFRESH, 4'd0, 3'd0, 2'd0, 8'd0, 2'd0));

    settle_and_load(16'd0);
    random_phase(18);
    settle_and_load(16'hffff);
    random_phase(18);
    settle_and_load(16'($urandom_range(1, 60)));
    random_phase(18);
    settle_and_load(TIMEOUT_RST);
    random_phase(18);
    settle_and_load(16'($urandom_range(0, 65535)));
    calm <= 1'b1;
    random_phase(18);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_motor_status_led_shift_driver: done, clean");
    end else begin
      $display("tb_motor_status_led_shift_driver: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/msld_pkg.sv
hdl/motor_status_led_shift_driver.sv
tb/msld_beat_checker.sv
tb/tb_motor_status_led_shift_driver.sv
